[sv/dcf_pkg.sv]
// shared types and constants of the dual circular fifo block
`default_nettype none
package dcf_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned STATUS_W  = 2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the accepted item
    logic exec;  // check pointers, access memory, update state
  } dcf_ctrl_t;

endpackage
`default_nettype wire

[sv/dcf_if.sv]
// valid/ready channel interfaces for items and results
`default_nettype none
interface dcf_in_if
  import dcf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic                     queue_sel;
  logic signed [WORD_W-1:0] data_in;

  modport source (output valid, output cmd, output queue_sel, output data_in, input ready);
  modport sink   (input valid, input cmd, input queue_sel, input data_in, output ready);
endinterface

interface dcf_out_if
  import dcf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] data_out;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output data_out, output status, input ready);
  modport sink   (input valid, input data_out, input status, output ready);
endinterface
`default_nettype wire

[sv/dcf_ram.sv]
// generic single port ram with registered read
`default_nettype none
module dcf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[sv/dcf_ctrl.sv]
// controller state machine: accept, execute, deliver result
`default_nettype none
module dcf_ctrl
  import dcf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output dcf_ctrl_t      ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          // read data lands in the ram output register here
          state_q     <= S_RESP;
          out_valid_q <= 1'b1;
        end
        S_RESP: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctrl_o.load = in_ready_q && in_valid_i;
    ctrl_o.exec = (state_q == S_EXEC);
  end

endmodule
`default_nettype wire

[sv/dcf_datapath.sv]
// datapath: item register, queue pointers, shared memory, result
`default_nettype none
module dcf_datapath
  import dcf_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire dcf_ctrl_t                ctrl_i,
  input  wire logic                     cmd_i,
  input  wire logic                     queue_sel_i,
  input  wire logic signed [WORD_W-1:0] data_in_i,
  output logic signed      [WORD_W-1:0] data_out_o,
  output logic             [STATUS_W-1:0] status_o
);

  localparam int unsigned HALF_LO = DEPTH / 2;
  localparam int unsigned HALF_HI = DEPTH - DEPTH / 2;
  localparam int unsigned PTR_W   = $clog2(HALF_HI);
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam logic [PTR_W-1:0]  LAST_LO = PTR_W'(HALF_LO - 1);
  localparam logic [PTR_W-1:0]  LAST_HI = PTR_W'(HALF_HI - 1);
  localparam logic [ADDR_W-1:0] BASE_HI = ADDR_W'(HALF_LO);

  logic                     cmd_q;
  logic                     sel_q;
  logic signed [WORD_W-1:0] data_q;

  logic [PTR_W-1:0] rp_lo_q, rp_lo_d, wp_lo_q, wp_lo_d;
  logic [PTR_W-1:0] rp_hi_q, rp_hi_d, wp_hi_q, wp_hi_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                deq_ok_q, deq_ok_d;

  logic [PTR_W-1:0]  rp_cur, wp_cur, last, ptr_sel, ptr_nxt;
  logic [ADDR_W-1:0] addr;
  logic              full, empty, ram_we, ram_re;
  logic [WORD_W-1:0] ram_rdata;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_i;
      sel_q  <= queue_sel_i;
      data_q <= data_in_i;
    end
  end

  always_comb begin
    rp_cur  = sel_q ? rp_hi_q : rp_lo_q;
    wp_cur  = sel_q ? wp_hi_q : wp_lo_q;
    last    = sel_q ? LAST_HI : LAST_LO;
    // enqueue advances the write pointer, dequeue the read pointer
    ptr_sel = (cmd_q == CMD_ENQ) ? wp_cur : rp_cur;
    ptr_nxt = (ptr_sel == last) ? '0 : ptr_sel + PTR_W'(1);
    full    = (ptr_nxt == rp_cur);
    empty   = (rp_cur == wp_cur);
    addr    = sel_q ? (BASE_HI + ADDR_W'(ptr_nxt)) : ADDR_W'(ptr_nxt);
    ram_we  = ctrl_i.exec && (cmd_q == CMD_ENQ) && !full;
    ram_re  = ctrl_i.exec && (cmd_q == CMD_DEQ) && !empty;

    rp_lo_d  = rp_lo_q;
    wp_lo_d  = wp_lo_q;
    rp_hi_d  = rp_hi_q;
    wp_hi_d  = wp_hi_q;
    status_d = status_q;
    deq_ok_d = deq_ok_q;
    if (ctrl_i.exec) begin
      deq_ok_d = ram_re;
      if (cmd_q == CMD_ENQ) begin
        status_d = full ? STATUS_FULL : STATUS_DONE;
        if (!full) begin
          if (sel_q) wp_hi_d = ptr_nxt;
          else       wp_lo_d = ptr_nxt;
        end
      end else begin
        status_d = empty ? STATUS_EMPTY : STATUS_DONE;
        if (!empty) begin
          if (sel_q) rp_hi_d = ptr_nxt;
          else       rp_lo_d = ptr_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_lo_q  <= '0;
      wp_lo_q  <= '0;
      rp_hi_q  <= '0;
      wp_hi_q  <= '0;
      status_q <= STATUS_DONE;
      deq_ok_q <= 1'b0;
    end else begin
      rp_lo_q  <= rp_lo_d;
      wp_lo_q  <= wp_lo_d;
      rp_hi_q  <= rp_hi_d;
      wp_hi_q  <= wp_hi_d;
      status_q <= status_d;
      deq_ok_q <= deq_ok_d;
    end
  end

  dcf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (addr),
    .wdata_i (data_q),
    .rdata_o (ram_rdata)
  );

  // ram output register holds until the next read
  assign data_out_o = deq_ok_q ? $signed(ram_rdata) : '0;
  assign status_o   = status_q;

endmodule
`default_nettype wire

[sv/dual_circular_fifo_shared_memory.sv]
// sequence: after the input transfer the controller steps through execute and then respond,
//   where the result is valid and waits for the receiver to take it
// flow: items are handled one at a time, set by the controller sequence and the
//   registered ram read; a new item is accepted only after the result is taken
// reset: rst_ni clears all four queue pointers so both queues start empty;
//   memory contents are not cleared and need no clearing pass
`default_nettype none
module dual_circular_fifo_shared_memory
  import dcf_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dcf_in_if.sink    in_i,
  dcf_out_if.source out_o
);

  dcf_ctrl_t ctrl;

  dcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  dcf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cmd_i       (in_i.cmd),
    .queue_sel_i (in_i.queue_sel),
    .data_in_i   (in_i.data_in),
    .data_out_o  (out_o.data_out),
    .status_o    (out_o.status)
  );

endmodule
`default_nettype wire

[verif/tb_dual_circular_fifo_shared_memory.sv]
// testbench of the dual circular fifo with shared memory: scoreboard, stimulus and checks
`default_nettype none

class fifo_pair_scoreboard #(int unsigned DEPTH = dcf_pkg::DEPTH_DEF);

  typedef struct packed {
    logic signed [dcf_pkg::WORD_W-1:0] data;
    logic [dcf_pkg::STATUS_W-1:0]      status;
  } fifo_result_t;

  localparam int unsigned HALF_LOW  = DEPTH / 2;
  localparam int unsigned HALF_HIGH = DEPTH - DEPTH / 2;

  logic [dcf_pkg::WORD_W-1:0] word_mem [DEPTH];
  int unsigned                rd_ptr   [2];
  int unsigned                wr_ptr   [2];
  fifo_result_t               expected_results [$];
  int unsigned                mismatches;

  function new();
    for (int i = 0; i < DEPTH; i++) word_mem[i] = '0;
    rd_ptr[0] = 0;
    rd_ptr[1] = 0;
    wr_ptr[0] = 0;
    wr_ptr[1] = 0;
    mismatches = 0;
  endfunction

  function int unsigned ring_step(int unsigned ptr, int unsigned size);
    return (ptr + 1 >= size) ? 0 : ptr + 1;
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

  function void report(string what);
    mismatches++;
    $display("mismatch: %s", what);
  endfunction

  // predict the outcome of one accepted request
  function void note_request(logic cmd, logic sel, logic [dcf_pkg::WORD_W-1:0] data);
    fifo_result_t res;
    int unsigned  size;
    int unsigned  base;
    int unsigned  nxt;
    size = sel ? HALF_HIGH : HALF_LOW;
    base = sel ? HALF_LOW : 0;
    res.data   = '0;
    res.status = dcf_pkg::STATUS_DONE;
    if (cmd == dcf_pkg::CMD_ENQ) begin
      nxt = ring_step(wr_ptr[sel], size);
      if (nxt == rd_ptr[sel]) begin
        res.status = dcf_pkg::STATUS_FULL;
      end else begin
        wr_ptr[sel] = nxt;
        word_mem[base + nxt] = data;
      end
    end else begin
      if (rd_ptr[sel] == wr_ptr[sel]) begin
        res.status = dcf_pkg::STATUS_EMPTY;
      end else begin
        nxt = ring_step(rd_ptr[sel], size);
        rd_ptr[sel] = nxt;
        res.data = word_mem[base + nxt];
      end
    end
    expected_results.push_back(res);
  endfunction

  function void check_response(logic signed [dcf_pkg::WORD_W-1:0] data,
                               logic [dcf_pkg::STATUS_W-1:0] status);
    fifo_result_t exp_res;
    if (expected_results.size() == 0) begin
      report($sformatf("response with none pending: data %h status %0d", data, status));
      return;
    end
    exp_res = expected_results.pop_front();
    if (data !== exp_res.data)
      report($sformatf("data_out %h, wanted %h", data, exp_res.data));
    if (status !== exp_res.status)
      report($sformatf("status %0d, wanted %0d", status, exp_res.status));
  endfunction

endclass

module tb_dual_circular_fifo_shared_memory;
  import dcf_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned cycles;
  logic [15:0] stall_pattern;
  logic [5:0]  stall_tick;

  fifo_pair_scoreboard #(DEPTH) sb;

  dcf_in_if  req_if ();
  dcf_out_if rsp_if ();

  dual_circular_fifo_shared_memory #(.DEPTH(DEPTH)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // transfer monitors
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready)
      sb.note_request(req_if.cmd, req_if.queue_sel, req_if.data_in);
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_response(rsp_if.data_out, rsp_if.status);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls on a pattern redrawn each time the 6-bit stall tick wraps, never stuck low
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready  <= 1'b0;
      stall_tick    <= '0;
      stall_pattern <= '1;
    end else begin
      stall_tick <= stall_tick + 6'd1;
      if (stall_tick == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          stall_pattern <= '1;
          rsp_if.ready  <= 1'b1;
        end else begin
          stall_pattern <= 16'($urandom) | 16'h0001;
          rsp_if.ready  <= 1'b1;
        end
      end else begin
        rsp_if.ready <= stall_pattern[stall_tick[3:0]];
      end
    end
  end

  task automatic push_item(logic cmd, logic sel, logic [WORD_W-1:0] data);
    req_if.valid     <= 1'b1;
    req_if.cmd       <= cmd;
    req_if.queue_sel <= sel;
    req_if.data_in   <= data;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int unsigned n);
    req_if.valid   <= 1'b0;
    req_if.data_in <= $urandom;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned enq_bias;
    int unsigned burst_left;
    logic        sel;
    logic        sticky_sel;
    logic        cmd;

    sb     = new();
    cycles = 0;
    rst_ni = 1'b0;
    req_if.valid     = 1'b0;
    req_if.cmd       = CMD_ENQ;
    req_if.queue_sel = 1'b0;
    req_if.data_in   = '0;
    rsp_if.ready     = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // both queues empty after reset
    push_item(CMD_DEQ, 1'b0, 32'h1234_5678);
    push_item(CMD_DEQ, 1'b1, 32'h0);
    // extremes into the upper queue
    push_item(CMD_ENQ, 1'b1, 32'h8000_0000);
    push_item(CMD_ENQ, 1'b1, 32'h7fff_ffff);
    push_item(CMD_ENQ, 1'b1, 32'hffff_ffff);
    push_item(CMD_ENQ, 1'b1, 32'h0000_0000);
    // fill the lower queue, then overflow it
    for (int i = 0; i < DEPTH / 2; i++) push_item(CMD_ENQ, 1'b0, $urandom);
    // fill the upper queue to its last free slot, then overflow it
    for (int i = 4; i < DEPTH - DEPTH / 2; i++) push_item(CMD_ENQ, 1'b1, pick_word());
    // drain the lower queue past empty
    for (int i = 0; i < DEPTH / 2; i++) push_item(CMD_DEQ, 1'b0, $urandom);

    wait_drained();

    enq_bias   = 50;
    burst_left = 0;
    sticky_sel = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_bias = 30;
          1:       enq_bias = 50;
          default: enq_bias = 70;
        endcase
        sticky_sel = 1'($urandom_range(0, 1));
      end
      if (n == RANDOM_ITEMS / 2) wait_drained();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      end
      burst_left--;
      sel = ($urandom_range(0, 3) == 0) ? ~sticky_sel : sticky_sel;
      cmd = ($urandom_range(1, 100) <= enq_bias) ? CMD_ENQ : CMD_DEQ;
      push_item(cmd, sel, pick_word());
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
